FILE: design/ghsa_pkg.sv
package ghsa_pkg;

  // Table geometry
  localparam int MaxSlots  = 256;
  localparam int SlotIdxW  = $clog2(MaxSlots);
  localparam int CountW    = $clog2(MaxSlots) + 1;
  localparam int GenBits   = 16;
  localparam int WorldW    = 16;

  // Stream payload widths
  localparam int InDataW   = 40;
  localparam int OutDataW  = 24;

  typedef logic [SlotIdxW-1:0] slot_idx_t;
  typedef logic [CountW-1:0]   slot_cnt_t;
  typedef logic [GenBits-1:0]  gen_t;
  typedef logic [WorldW-1:0]   world_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // A free stack entry keeps the generation the slot got at release
  typedef struct packed {
    slot_idx_t idx;
    gen_t      gen;
  } stk_entry_t;

  typedef struct packed {
    logic       en;
    slot_idx_t  addr;
    stk_entry_t data;
  } stk_wr_t;

  // A slot entry holds the live mark next to the generation
  typedef struct packed {
    logic live;
    gen_t gen;
  } slot_ent_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    slot_ent_t data;
  } gen_wr_t;

endpackage

FILE: design/ghsa_gen_store.sv
module ghsa_gen_store (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  ghsa_pkg::slot_idx_t rd_addr_i,
  input  ghsa_pkg::gen_wr_t   wr_i,
  output ghsa_pkg::slot_ent_t rd_data_o
);
  import ghsa_pkg::*;

  slot_ent_t gen_mem [MaxSlots];
  slot_ent_t rd_q;
  slot_ent_t fwd_data_q;
  logic      fwd_q;

  // Write one slot entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      gen_mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read; remember a same-cycle write to the same slot
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= gen_mem[rd_addr_i];
      fwd_q      <= wr_i.en && (wr_i.addr == rd_addr_i);
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

FILE: design/ghsa_free_stack.sv
module ghsa_free_stack (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  ghsa_pkg::slot_idx_t   rd_addr_i,
  input  ghsa_pkg::stk_wr_t     wr_i,
  output ghsa_pkg::stk_entry_t  rd_data_o
);
  import ghsa_pkg::*;

  stk_entry_t stk_mem [MaxSlots];
  stk_entry_t rd_q;
  stk_entry_t fwd_data_q;
  logic       fwd_q;

  // Push writes the entry at the current fill count
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      stk_mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Prefetch the top of stack; bypass a push landing on it
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= stk_mem[rd_addr_i];
      fwd_q      <= wr_i.en && (wr_i.addr == rd_addr_i);
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

FILE: design/generation_handle_slot_allocator.sv
// Channel   | Direction | tdata (low bit up)                      | tuser
// ----------+-----------+-----------------------------------------+--------
// s_axis    | in        | handle_world, handle_index, handle_gen  | opcode
// m_axis    | out       | slot_index, slot_generation             | status
// cfg       | in        | world_id (write enable + data)          | -
//
// One transaction per cycle is accepted while s_axis_tready is high. A request
// passes the request stage, where the registered read of the slot store and the free
// stack top, issued while the request is taken, returns, and then the result register.
// Reset clears the fill counts, valid bits and world id, not the memories: live marks
// sit beside the generations and every slot below the used count was written when
// appended, so no clearing pass is needed. A stalled result register holds the request
// stage, and s_axis_tready falls only when the request stage is occupied and the result
// register holds a transaction with m_axis_tready low.
module generation_handle_slot_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ghsa_pkg::InDataW-1:0] s_axis_tdata,
    // handle_world[15:0], handle_index[23:16], handle_gen[39:24]
  input  logic [1:0]                   s_axis_tuser,  // opcode[1:0]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ghsa_pkg::OutDataW-1:0] m_axis_tdata, // slot_index[7:0], slot_generation[23:8]
  output logic [1:0]                   m_axis_tuser   // status[1:0]
);
  import ghsa_pkg::*;

  world_t             world_id_q;
  slot_cnt_t          free_cnt_q, free_cnt_d;
  slot_cnt_t          used_q, used_d;

  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  world_t             s1_world_q;
  slot_idx_t          s1_index_q;
  gen_t               s1_gen_q;

  logic               out_valid_q;
  status_e            out_status_q, out_status_d;
  slot_idx_t          out_index_q, out_index_d;
  gen_t               out_gen_q, out_gen_d;

  logic               out_free;
  logic               s1_adv;
  logic               in_accept;
  logic               hit;
  logic               do_pop;
  logic               do_push;
  slot_ent_t          slot_rd;
  stk_entry_t         stk_top;
  slot_idx_t          stk_rd_addr;
  gen_wr_t            gen_wr;
  stk_wr_t            stk_wr;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_id_q <= world_t'(1);
    end else if (cfg_we_i) begin
      world_id_q <= cfg_wdata_i;
    end
  end

  // Request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= s_axis_tuser;
      s1_world_q <= s_axis_tdata[15:0];
      s1_index_q <= s_axis_tdata[23:16];
      s1_gen_q   <= s_axis_tdata[39:24];
    end
  end

  // Memories: read addresses follow the incoming request and the next fill count
  ghsa_gen_store u_gen_store (
    .clk_i     (clk_i),
    .rd_en_i   (s_axis_tready),
    .rd_addr_i (s_axis_tdata[23:16]),
    .wr_i      (gen_wr),
    .rd_data_o (slot_rd)
  );

  ghsa_free_stack u_free_stack (
    .clk_i     (clk_i),
    .rd_en_i   (s_axis_tready),
    .rd_addr_i (stk_rd_addr),
    .wr_i      (stk_wr),
    .rd_data_o (stk_top)
  );

  // Validate the handle held in the request stage
  assign hit = (s1_world_q == world_id_q)
            && ({1'b0, s1_index_q} < used_q)
            && slot_rd.live
            && (slot_rd.gen == s1_gen_q);

  // Decide the operation and its state updates
  always_comb begin
    free_cnt_d   = free_cnt_q;
    used_d       = used_q;
    do_pop       = 1'b0;
    do_push      = 1'b0;
    gen_wr       = '0;
    stk_wr       = '0;
    out_status_d = ST_INVALID;
    out_index_d  = s1_index_q;
    out_gen_d    = '0;
    unique case (s1_op_q)
      OP_ALLOC: begin
        if (free_cnt_q != '0) begin
          do_pop           = 1'b1;
          free_cnt_d       = free_cnt_q - slot_cnt_t'(1);
          gen_wr.en        = s1_adv;
          gen_wr.addr      = stk_top.idx;
          gen_wr.data.live = 1'b1;
          gen_wr.data.gen  = stk_top.gen + gen_t'(1);
          out_status_d     = ST_OK;
          out_index_d      = stk_top.idx;
          out_gen_d        = gen_wr.data.gen;
        end else if (used_q < slot_cnt_t'(MaxSlots)) begin
          used_d           = used_q + slot_cnt_t'(1);
          gen_wr.en        = s1_adv;
          gen_wr.addr      = used_q[SlotIdxW-1:0];
          gen_wr.data.live = 1'b1;
          gen_wr.data.gen  = gen_t'(1);
          out_status_d     = ST_OK;
          out_index_d      = used_q[SlotIdxW-1:0];
          out_gen_d        = gen_t'(1);
        end else begin
          out_status_d = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (hit && (free_cnt_q < slot_cnt_t'(MaxSlots))) begin
          do_push          = 1'b1;
          free_cnt_d       = free_cnt_q + slot_cnt_t'(1);
          gen_wr.en        = s1_adv;
          gen_wr.addr      = s1_index_q;
          gen_wr.data.live = 1'b0;
          gen_wr.data.gen  = slot_rd.gen + gen_t'(1);
          stk_wr.en        = s1_adv;
          stk_wr.addr      = free_cnt_q[SlotIdxW-1:0];
          stk_wr.data.idx  = s1_index_q;
          stk_wr.data.gen  = slot_rd.gen + gen_t'(1);
          out_status_d     = ST_OK;
        end
      end
      OP_CHECK: begin
        if (hit) begin
          out_status_d = ST_OK;
        end
      end
      default: begin
        out_status_d = ST_INVALID;
      end
    endcase
  end

  // Prefetch the entry that will be on top after this cycle's update
  always_comb begin
    priority if (s1_adv && do_push) begin
      stk_rd_addr = free_cnt_q[SlotIdxW-1:0];
    end else if (s1_adv && do_pop) begin
      stk_rd_addr = free_cnt_q[SlotIdxW-1:0] - slot_idx_t'(2);
    end else begin
      stk_rd_addr = free_cnt_q[SlotIdxW-1:0] - slot_idx_t'(1);
    end
  end

  // Commit state when the request moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= '0;
      used_q     <= '0;
    end else if (s1_adv) begin
      free_cnt_q <= free_cnt_d;
      used_q     <= used_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= out_status_d;
      out_index_q  <= out_index_d;
      out_gen_q    <= out_gen_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_gen_q, out_index_q};

endmodule

FILE: design/ghsa_checker.sv
module ghsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ghsa_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);
  import ghsa_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result transaction changed while stalled");

  // Drop ready only when a result is waiting and blocked
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Carry no generation on a rejected or full result
  a_gen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[23:8] == '0)
    else $error("nonzero generation on a failed result");

  // Never report a status code outside the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_INVALID)
      || (m_axis_tuser == ST_FULL))
    else $error("undefined status on result");

endmodule

bind generation_handle_slot_allocator ghsa_checker u_ghsa_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ghsa_pkg::*;

  localparam logic [1:0] OpReserved   = 2'd3;
  localparam int         MaxWait      = 18;
  localparam int         SettleCycles = 8;
  localparam int         StallCycles  = 300;
  localparam int         ChurnRounds  = 60;
  localparam int         PhaseItems   = 120;
  localparam longint     CycleLimit   = 1_000_000;

  typedef struct packed {
    status_e   status;
    slot_idx_t index;
    gen_t      gen;
  } slot_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;  // handle_world[15:0], handle_index[23:16], handle_gen[39:24]
  logic [1:0]  s_axis_tuser;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;  // slot_index[7:0], slot_generation[23:8]
  logic [1:0]  m_axis_tuser;  // status[1:0]

  // Shadow copy of the handle table
  world_t    world_reg;
  gen_t      gen_mem [MaxSlots];
  logic      live_mem [MaxSlots];
  slot_idx_t free_stk [MaxSlots];
  int        free_cnt;
  int        used_cnt;
  int        live_q[$];

  slot_reply_t pending_replies[$];
  slot_reply_t last_reply;

  bit     src_idle  = 1'b1;
  bit     sink_idle = 1'b1;
  int     sink_wait = 0;
  int     hold_left = 0;
  int     errors = 0;
  int     sent_cnt = 0;
  int     reply_cnt = 0;
  int     full_cnt = 0;
  int     world_writes = 0;
  longint cycles = 0;

  generation_handle_slot_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Run length watchdog
  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

  // Work out the reply to one request and update the shadow table
  function automatic slot_reply_t predict_reply(input logic [1:0] op, input world_t world,
                                                input slot_idx_t idx, input gen_t gen);
    slot_reply_t r;
    slot_idx_t   pick;
    logic        handle_ok;
    r.status  = ST_INVALID;
    r.index   = idx;
    r.gen     = '0;
    handle_ok = (world == world_reg) && (int'(idx) < used_cnt) && live_mem[idx] &&
                (gen_mem[idx] == gen);
    case (op)
      OP_ALLOC: begin
        if (free_cnt > 0 || used_cnt < MaxSlots) begin
          if (free_cnt > 0) begin
            // pop the most recently freed slot
            free_cnt--;
            pick = free_stk[free_cnt];
            gen_mem[pick] = gen_mem[pick] + gen_t'(1);
          end else begin
            // append a fresh slot
            pick = slot_idx_t'(used_cnt);
            used_cnt++;
            gen_mem[pick] = gen_t'(1);
          end
          live_mem[pick] = 1'b1;
          live_q.push_back(int'(pick));
          r.status = ST_OK;
          r.index  = pick;
          r.gen    = gen_mem[pick];
        end else begin
          r.status = ST_FULL;
          full_cnt++;
        end
      end
      OP_RELEASE: begin
        if (handle_ok && free_cnt < MaxSlots) begin
          live_mem[idx] = 1'b0;
          gen_mem[idx]  = gen_mem[idx] + gen_t'(1);
          free_stk[free_cnt] = idx;
          free_cnt++;
          for (int k = 0; k < live_q.size(); k++) begin
            if (live_q[k] == int'(idx)) begin
              live_q.delete(k);
              break;
            end
          end
          r.status = ST_OK;
        end
      end
      OP_CHECK: begin
        if (handle_ok) r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request and queue its reply once the transaction completes
  task automatic send_item(input logic [1:0] op, input world_t world, input slot_idx_t idx,
                           input gen_t gen);
    int gap;
    gap = src_idle ? $urandom_range(0, MaxWait) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {gen, idx, world};
    do @(posedge clk_i); while (!s_axis_tready);
    last_reply = predict_reply(op, world, idx, gen);
    pending_replies.push_back(last_reply);
    sent_cnt++;
  endtask

  task automatic send_alloc();
    send_item(OP_ALLOC, world_t'($urandom), slot_idx_t'($urandom), gen_t'($urandom));
  endtask

  // Handle with exactly one defect: generation, world, index or staleness
  task automatic send_broken_handle();
    logic [1:0] op;
    world_t     world;
    slot_idx_t  idx;
    gen_t       gen;
    int         tries;
    op  = $urandom_range(0, 1) ? OP_RELEASE : OP_CHECK;
    idx = (live_q.size() > 0) ? slot_idx_t'(live_q[$urandom_range(0, live_q.size() - 1)])
                              : slot_idx_t'($urandom);
    world = world_reg;
    gen   = gen_mem[idx];
    case ($urandom_range(0, 3))
      0: gen = gen + gen_t'($urandom_range(1, 16'hFFFF));
      1: world = world ^ world_t'($urandom_range(1, 16'hFFFF));
      2: begin
        if (used_cnt < MaxSlots) idx = slot_idx_t'($urandom_range(used_cnt, MaxSlots - 1));
        gen = gen_t'($urandom);
      end
      default: begin
        // released slot presented with the generation it had while live
        for (tries = 0; tries < 8 && used_cnt > 0; tries++) begin
          idx = slot_idx_t'($urandom_range(0, used_cnt - 1));
          if (!live_mem[idx]) break;
        end
        gen = gen_mem[idx] - gen_t'(1);
      end
    endcase
    send_item(op, world, idx, gen);
  endtask

  task automatic send_random_request(input int alloc_pct);
    int         roll;
    int         idx;
    logic [1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct || (roll < 75 && live_q.size() == 0)) begin
      send_alloc();
    end else if (roll < 75) begin
      idx = live_q[$urandom_range(0, live_q.size() - 1)];
      op  = $urandom_range(0, 1) ? OP_RELEASE : OP_CHECK;
      send_item(op, world_reg, slot_idx_t'(idx), gen_mem[idx]);
    end else if (roll < 90) begin
      send_broken_handle();
    end else begin
      send_item(2'($urandom), world_t'($urandom), slot_idx_t'($urandom), gen_t'($urandom));
    end
  endtask

  // Drop valid and wait until every reply is back
  task automatic await_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_world(input world_t value);
    await_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    world_reg = value;
    world_writes++;
  endtask

  // Receiver: idle per reply, plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each reply with the oldest pending one
  always @(posedge clk_i) begin
    slot_reply_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      sink_wait = sink_idle ? $urandom_range(0, MaxWait) : 0;
      reply_cnt++;
      if (pending_replies.size() == 0) begin
        errors++;
        $error("unexpected reply: status %0d slot_index %0d slot_generation %0d",
               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8]);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.status) begin
          errors++;
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
        end
        if (m_axis_tdata[7:0] !== want.index) begin
          errors++;
          $error("slot_index: expected %0d, got %0d", want.index, m_axis_tdata[7:0]);
        end
        if (m_axis_tdata[23:8] !== want.gen) begin
          errors++;
          $error("slot_generation: expected %0d, got %0d", want.gen, m_axis_tdata[23:8]);
        end
      end
    end
  end

  // Each operation on a tiny table, every rejection reason, reserved opcode
  task automatic test_basic_ops();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_item(OP_CHECK, 16'd1, 8'd0, 16'd0);
    send_item(OP_RELEASE, 16'd1, 8'd0, 16'd1);
    send_alloc();
    send_alloc();
    send_item(OP_CHECK, 16'd1, 8'd0, 16'd1);
    send_item(OP_CHECK, 16'd2, 8'd0, 16'd1);
    send_item(OP_CHECK, 16'd1, 8'd0, 16'd2);
    send_item(OP_CHECK, 16'd1, 8'd2, 16'd1);
    send_item(OP_RELEASE, 16'd1, 8'd0, 16'd1);
    send_item(OP_CHECK, 16'd1, 8'd0, 16'd1);
    send_item(OP_RELEASE, 16'd1, 8'd0, 16'd2);
    send_alloc();
    send_item(OpReserved, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(OpReserved, 16'd1, 8'd0, gen_mem[0]);
    send_item(OP_CHECK, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(OP_RELEASE, 16'd1, 8'd1, 16'd1);
    send_item(OP_RELEASE, 16'd1, 8'd0, gen_mem[0]);
    send_alloc();
    send_alloc();
    send_alloc();
    send_item(OP_CHECK, 16'd1, 8'd2, 16'd1);
  endtask

  // World id extremes: old handles turn foreign, new ones pass
  task automatic test_world_register();
    write_world(16'h0000);
    send_item(OP_CHECK, 16'd1, 8'd2, gen_mem[2]);
    send_item(OP_CHECK, 16'h0000, 8'd2, gen_mem[2]);
    send_alloc();
    write_world(16'hFFFF);
    send_item(OP_CHECK, 16'h0000, 8'd2, gen_mem[2]);
    send_item(OP_RELEASE, 16'hFFFF, 8'd2, gen_mem[2]);
    write_world(world_t'($urandom));
    repeat (10) send_random_request(40);
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls
  task automatic test_input_stall();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    hold_left = StallCycles;
    repeat (60) send_random_request(40);
  endtask

  // Cycle one slot through release and allocate back to back
  task automatic test_slot_churn();
    int slot;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    if (live_q.size() == 0) send_alloc();
    slot = live_q[0];
    repeat (ChurnRounds) begin
      send_item(OP_RELEASE, world_reg, slot_idx_t'(slot), gen_mem[slot]);
      send_alloc();
    end
  endtask

  // Fill every slot, then ask for more
  task automatic test_table_full();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    while (free_cnt > 0 || used_cnt < MaxSlots) send_alloc();
    repeat (3) send_alloc();
    send_item(OP_CHECK, world_reg, 8'hFF, gen_mem[255]);
    send_item(OP_RELEASE, world_reg, 8'hFF, gen_mem[255]);
    send_alloc();
    send_alloc();
  endtask

  // Mixed traffic in phases with different allocate share and world id
  task automatic test_random_traffic();
    int     alloc_pct [5] = '{60, 40, 15, 30, 50};
    world_t phase_world;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: phase_world = 16'h0000;
        1: phase_world = 16'hFFFF;
        3: phase_world = 16'd1;
        default: phase_world = world_t'($urandom);
      endcase
      write_world(phase_world);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 30 == 0) begin
          src_idle  = ($urandom_range(0, 3) != 0);
          sink_idle = ($urandom_range(0, 3) != 0);
        end
        send_random_request(alloc_pct[p]);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;

    // shadow table after reset
    world_reg = 16'd1;
    free_cnt  = 0;
    used_cnt  = 0;
    foreach (gen_mem[k]) begin
      gen_mem[k]  = '0;
      live_mem[k] = 1'b0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_world_register();
    test_input_stall();
    test_slot_churn();
    test_table_full();
    test_random_traffic();
    await_idle();

    $display("Sent %0d requests under %0d world id writes; %0d full replies.",
             sent_cnt, world_writes, full_cnt);
    $display("Checked %0d replies, %0d mismatches.", reply_cnt, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
